[sv/e2q_pkg.sv]
// e2q_pkg: shared constants, types and cordic arc table for euler_to_quaternion
// no dependencies
package e2q_pkg;

   localparam int CordicSteps = 30;
   localparam int CordicWidth = 34;
   localparam int FracBits    = 30;

   localparam logic signed [CordicWidth-1:0] Q30Pi     = 34'sd3373259426;
   localparam logic signed [CordicWidth-1:0] Q30HalfPi = 34'sd1686629713;
   localparam logic signed [CordicWidth-1:0] Q30Gain   = 34'sd652032874;

   typedef enum logic [0:0] {
      ORDER_123 = 1'b0,
      ORDER_321 = 1'b1
   } order_type;

   typedef enum logic [0:0] {
      ADDR_ROTATION_ORDER = 1'b0
   } reg_addr_type;

   typedef logic signed [CordicWidth-1:0] cordic_word_type;

   function automatic cordic_word_type arc_at(input logic [4:0] idx);
      cordic_word_type r;
      r = '0;
      unique case (idx)
         5'd0:  r = 34'sd843314857;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043837;
         5'd3:  r = 34'sd133525159;
         5'd4:  r = 34'sd67021687;
         5'd5:  r = 34'sd33543516;
         5'd6:  r = 34'sd16775851;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194283;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048576;
         5'd11: r = 34'sd524288;
         5'd12: r = 34'sd262144;
         5'd13: r = 34'sd131072;
         5'd14: r = 34'sd65536;
         5'd15: r = 34'sd32768;
         5'd16: r = 34'sd16384;
         5'd17: r = 34'sd8192;
         5'd18: r = 34'sd4096;
         5'd19: r = 34'sd2048;
         5'd20: r = 34'sd1024;
         5'd21: r = 34'sd512;
         5'd22: r = 34'sd256;
         5'd23: r = 34'sd128;
         5'd24: r = 34'sd64;
         5'd25: r = 34'sd32;
         5'd26: r = 34'sd16;
         5'd27: r = 34'sd8;
         5'd28: r = 34'sd4;
         5'd29: r = 34'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[sv/e2q_cordic.sv]
// e2q_cordic: pipelined 30-stage rotation cordic, one half angle per lane
// depends on e2q_pkg
module e2q_cordic #(
   parameter int ANGLE_WIDTH = 18
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [ANGLE_WIDTH-1:0]  angle,
   output e2q_pkg::cordic_word_type       cos_out,
   output e2q_pkg::cordic_word_type       sin_out
);

   localparam int N = e2q_pkg::CordicSteps;
   localparam int W = e2q_pkg::CordicWidth;

   e2q_pkg::cordic_word_type x_ff [N+1];
   e2q_pkg::cordic_word_type y_ff [N+1];
   e2q_pkg::cordic_word_type z_ff [N+1];
   logic                     flip_ff [N+1];

   e2q_pkg::cordic_word_type h_in;
   e2q_pkg::cordic_word_type z0_in;
   logic                     flip_in;

   // angle in Q3.(ANGLE_WIDTH-3) scaled to Q.29, read as Q.30 half angle
   assign h_in = W'(angle) <<< (32 - ANGLE_WIDTH);

   always_comb begin
      z0_in   = h_in;
      flip_in = 1'b0;
      if (h_in > e2q_pkg::Q30HalfPi) begin
         z0_in   = h_in - e2q_pkg::Q30Pi;
         flip_in = 1'b1;
      end else if (h_in < -e2q_pkg::Q30HalfPi) begin
         z0_in   = h_in + e2q_pkg::Q30Pi;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= e2q_pkg::Q30Gain;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      e2q_pkg::cordic_word_type xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - e2q_pkg::arc_at(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + e2q_pkg::arc_at(5'(i));
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign cos_out = flip_ff[N] ? -x_ff[N] : x_ff[N];
   assign sin_out = flip_ff[N] ? -y_ff[N] : y_ff[N];

endmodule

[sv/e2q_combine.sv]
// e2q_combine: triple products, sign pattern, rounding and saturation
// depends on e2q_pkg
module e2q_combine #(
   parameter int OUT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic                          order,
   input  e2q_pkg::cordic_word_type      c1, s1, c2, s2, c3, s3,
   output logic signed [OUT_WIDTH-1:0]   quat_w,
   output logic signed [OUT_WIDTH-1:0]   quat_x,
   output logic signed [OUT_WIDTH-1:0]   quat_y,
   output logic signed [OUT_WIDTH-1:0]   quat_z
);

   localparam int W  = e2q_pkg::CordicWidth;
   localparam int FB = e2q_pkg::FracBits;
   localparam int PW = 2 * W;
   localparam int F  = OUT_WIDTH - 1;
   localparam int SW = W + 2;

   // pair products, stage 1 (c1c2, s1s2, s1c2, c1s2, registered with c3 and s3)
   logic signed [W-1:0] ab_ff [4];
   logic signed [W-1:0] c3_ff, s3_ff;
   logic                order1_ff, order2_ff;
   logic signed [W-1:0] t_ff [8];
   logic signed [SW-1:0] sum_ff [4];
   logic signed [PW-1:0] p_in [4];
   logic signed [PW-1:0] q_in [8];
   logic signed [PW-1:0] pa, pb;

   assign p_in[0] = PW'(c1) * PW'(c2);
   assign p_in[1] = PW'(s1) * PW'(s2);
   assign p_in[2] = PW'(s1) * PW'(c2);
   assign p_in[3] = PW'(c1) * PW'(s2);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) ab_ff[k] <= W'(p_in[k] >>> FB);
         c3_ff     <= c3;
         s3_ff     <= s3;
         order1_ff <= order;
      end
   end

   // ccc sss scc css csc scs ccs ssc
   always_comb begin
      pa = '0;
      pb = '0;
      q_in[0] = PW'(ab_ff[0]) * PW'(c3_ff);
      q_in[1] = PW'(ab_ff[1]) * PW'(s3_ff);
      q_in[2] = PW'(ab_ff[2]) * PW'(c3_ff);
      q_in[3] = PW'(ab_ff[3]) * PW'(s3_ff);
      q_in[4] = PW'(ab_ff[3]) * PW'(c3_ff);
      q_in[5] = PW'(ab_ff[2]) * PW'(s3_ff);
      q_in[6] = PW'(ab_ff[0]) * PW'(s3_ff);
      q_in[7] = PW'(ab_ff[1]) * PW'(c3_ff);
      pa = q_in[0];
      pb = q_in[1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 8; k++) t_ff[k] <= W'(q_in[k] >>> FB);
         order2_ff <= order1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            if ((order2_ff == e2q_pkg::ORDER_123) == (k % 2 == 0))
               sum_ff[k] <= SW'(t_ff[2*k]) - SW'(t_ff[2*k+1]);
            else
               sum_ff[k] <= SW'(t_ff[2*k]) + SW'(t_ff[2*k+1]);
         end
      end
   end

   function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [SW-1:0] v);
      logic signed [SW+2:0] r;
      logic signed [SW+2:0] top;
      logic signed [SW+2:0] bot;
      top = (SW+3)'((64'sd1 <<< F) - 64'sd1);
      bot = -top - 1;
      if (F < FB)
         r = ((SW+3)'(v) + ((SW+3)'(1) <<< (FB - 1 - F))) >>> (FB - F);
      else
         r = (SW+3)'(v) <<< (F - FB);
      if (r > top) r = top;
      if (r < bot) r = bot;
      return OUT_WIDTH'(r);
   endfunction

   logic unused_p;
   assign unused_p = ^{pa, pb};

   assign quat_w = to_out(sum_ff[0]);
   assign quat_x = to_out(sum_ff[1]);
   assign quat_y = to_out(sum_ff[2]);
   assign quat_z = to_out(sum_ff[3]);

endmodule

[sv/euler_to_quaternion_top.sv]
// euler_to_quaternion_top: stream wrapper, csr port and lanes
// depends on e2q_pkg, e2q_cordic, e2q_combine
//
// converts three euler angles (radians, signed Q3.(ANGLE_WIDTH-3)) into a
// quaternion (signed Q1.(OUT_WIDTH-1), saturated) using three cordic lanes,
// one per angle, and a merging stage of triple products. one transaction can
// be taken every cycle unless the output stalls; the data passes one entry
// register, 30 cordic stages, two multiplier stages, one sum stage and one
// output register. the pipeline advances whenever the output register is
// empty or being drained, so rsp_tready stalls the whole pipe.
// rotation_order at csr address 0: 0 = 1-2-3, 1 = 3-2-1; write only when idle
module euler_to_quaternion_top #(
   parameter int ANGLE_WIDTH = 18,
   parameter int OUT_WIDTH   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // first_angle, second_angle, third_angle from bit 0 up, zero padded
   input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded
   output logic [((4*OUT_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [1:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int Latency = e2q_pkg::CordicSteps + 4;
   localparam int InW     = ((3*ANGLE_WIDTH+7)/8)*8;
   localparam int OutW    = ((4*OUT_WIDTH+7)/8)*8;

   logic                   order_ff;
   logic [Latency-1:0]     vld_ff;
   logic                   out_vld_ff;
   logic [OutW-1:0]        out_data_ff;
   logic                   adv;
   e2q_pkg::cordic_word_type c [3];
   e2q_pkg::cordic_word_type s [3];
   logic signed [OUT_WIDTH-1:0] qw, qx, qy, qz;
   logic signed [ANGLE_WIDTH-1:0] ang [3];
   logic                   csr_wr;
   logic [InW-1:0]         unused_in;

   // csr: single register at byte address 0
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = {31'd0, order_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= e2q_pkg::ORDER_123;
      end else if (csr_wr && csr_paddr == 2'(e2q_pkg::ADDR_ROTATION_ORDER)) begin
         order_ff <= csr_pwdata[0];
      end
   end

   // pipeline moves unless the output holds an untaken result
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      assign ang[k] = req_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH];
      e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
         .clock   (clock),
         .en      (adv),
         .angle   (ang[k]),
         .cos_out (c[k]),
         .sin_out (s[k])
      );
   end

   e2q_combine #(.OUT_WIDTH(OUT_WIDTH)) u_combine (
      .clock  (clock),
      .en     (adv),
      .order  (order_ff),
      .c1 (c[0]), .s1 (s[0]), .c2 (c[1]), .s2 (s[1]), .c3 (c[2]), .s3 (s[2]),
      .quat_w (qw), .quat_x (qx), .quat_y (qy), .quat_z (qz)
   );

   // valid shift line alongside the data stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[Latency-2:0], req_tvalid};
         out_vld_ff <= vld_ff[Latency-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) out_data_ff <= OutW'({qz, qy, qx, qw});
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign unused_in  = req_tdata;

   // held result stays while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // input is refused only while output is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input refused without stall");
   // pipeline frozen during stall
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved under stall");

endmodule

[verif/euler_to_quaternion_top_tb.sv]
// euler_to_quaternion_top_tb: self-checking bench for the euler to quaternion block
// depends on e2q_pkg and euler_to_quaternion_top; a scoreboard class predicts each quaternion
`timescale 1ns / 1ps

module euler_to_quaternion_top_tb;

   localparam int AW = 18;
   localparam int OW = 16;
   localparam int WatchdogLimit = 3000;
   localparam int HoldCycles = 300;

   typedef struct packed {
      logic signed [OW-1:0] z;
      logic signed [OW-1:0] y;
      logic signed [OW-1:0] x;
      logic signed [OW-1:0] w;
   } quat_type;

   // quaternion predictor and queue of expected quaternions
   class quat_scoreboard;
      e2q_pkg::order_type order;
      quat_type  pending_quats[$];
      int        errors;
      int        n_inputs;
      int        n_results;
      int        n_saturated;
      longint    arcs[e2q_pkg::CordicSteps] = '{
         843314857, 497837829, 263043837, 133525159, 67021687,
         33543516, 16775851, 8388437, 4194283, 2097149,
         1048576, 524288, 262144, 131072, 65536,
         32768, 16384, 8192, 4096, 2048,
         1024, 512, 256, 128, 64,
         32, 16, 8, 4, 2};

      function new();
         order = e2q_pkg::ORDER_123;
         errors = 0;
         n_inputs = 0;
         n_results = 0;
         n_saturated = 0;
      endfunction

      // half angle in Q.30, folded into +/-pi/2, then a 30-step rotation
      function void half_sin_cos(input logic signed [AW-1:0] angle,
                                 output longint c, output longint s);
         longint x, y, z, nx;
         bit     flip;
         x = longint'(e2q_pkg::Q30Gain);
         y = 0;
         z = longint'(angle) * (64'sd1 <<< (32 - AW));
         flip = 0;
         if (z > longint'(e2q_pkg::Q30HalfPi)) begin
            z -= longint'(e2q_pkg::Q30Pi);
            flip = 1;
         end else if (z < -longint'(e2q_pkg::Q30HalfPi)) begin
            z += longint'(e2q_pkg::Q30Pi);
            flip = 1;
         end
         for (int i = 0; i < e2q_pkg::CordicSteps; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= arcs[i];
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += arcs[i];
            end
            x = nx;
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function longint prod3(longint a, longint b, longint c);
         return (((a * b) >>> e2q_pkg::FracBits) * c) >>> e2q_pkg::FracBits;
      endfunction

      // round half up to Q1.15 and clamp
      function logic signed [OW-1:0] round_sat(longint v);
         longint r;
         r = (v + (64'sd1 <<< (e2q_pkg::FracBits - OW)))
             >>> (e2q_pkg::FracBits - OW + 1);
         if (r > (2 ** (OW - 1)) - 1) begin
            r = (2 ** (OW - 1)) - 1;
            n_saturated++;
         end
         if (r < -(2 ** (OW - 1))) r = -(2 ** (OW - 1));
         return r[OW-1:0];
      endfunction

      function void note_input(logic [55:0] data);
         longint   c1, s1, c2, s2, c3, s3;
         longint   ccc, sss, scc, css, csc, scs, ccs, ssc;
         quat_type q;
         half_sin_cos(data[AW-1:0], c1, s1);
         half_sin_cos(data[2*AW-1:AW], c2, s2);
         half_sin_cos(data[3*AW-1:2*AW], c3, s3);
         ccc = prod3(c1, c2, c3);
         sss = prod3(s1, s2, s3);
         scc = prod3(s1, c2, c3);
         css = prod3(c1, s2, s3);
         csc = prod3(c1, s2, c3);
         scs = prod3(s1, c2, s3);
         ccs = prod3(c1, c2, s3);
         ssc = prod3(s1, s2, c3);
         if (order == e2q_pkg::ORDER_123) begin
            q.w = round_sat(ccc - sss);
            q.x = round_sat(scc + css);
            q.y = round_sat(csc - scs);
            q.z = round_sat(ccs + ssc);
         end else begin
            q.w = round_sat(ccc + sss);
            q.x = round_sat(scc - css);
            q.y = round_sat(csc + scs);
            q.z = round_sat(ccs - ssc);
         end
         pending_quats.insert(pending_quats.size(), q);
         n_inputs++;
      endfunction

      function void check_result(logic [63:0] data);
         quat_type got, want;
         got = data;
         n_results++;
         if (pending_quats.size() == 0) begin
            $error("unexpected result transaction %h", data);
            errors++;
            return;
         end
         want = pending_quats.pop_front();
         if (got.w !== want.w) begin
            $error("quat_w expected %0d actual %0d", want.w, got.w);
            errors++;
         end
         if (got.x !== want.x) begin
            $error("quat_x expected %0d actual %0d", want.x, got.x);
            errors++;
         end
         if (got.y !== want.y) begin
            $error("quat_y expected %0d actual %0d", want.y, got.y);
            errors++;
         end
         if (got.z !== want.z) begin
            $error("quat_z expected %0d actual %0d", want.z, got.z);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // first_angle, second_angle, third_angle from bit 0 up, zero padded
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // quat_w, quat_x, quat_y, quat_z from bit 0 up
   logic [63:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   quat_scoreboard sb;
   bit idle_on;     // random idling on both sides
   bit hold_req;    // asks the receiver for one long hold-off
   int quiet_cycles;

   euler_to_quaternion_top #(
      .ANGLE_WIDTH(AW),
      .OUT_WIDTH  (OW)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watch both channels; values seen here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog: too long without any transaction
   always @(posedge clock) begin
      if (quiet_cycles >= WatchdogLimit) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            rsp_tready <= !reset && (!idle_on || $urandom_range(99) >= 18);
         end
      end
   end

   // offer one transaction, idling first at random, and wait for acceptance
   task automatic send_angles(input logic [AW-1:0] a1, input logic [AW-1:0] a2,
                              input logic [AW-1:0] a3);
      bit accepted;
      if (idle_on) begin
         while ($urandom_range(99) < 18) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      // pad bits are junk that the block must ignore
      req_tdata  <= {2'($urandom), a3, a2, a1};
      // ready is settled by the falling edge and holds until the next rising edge
      do begin
         @(negedge clock);
         accepted = req_tready;
         @(posedge clock);
      end while (!accepted);
   endtask

   // setup then access phase; register takes the value at the access edge
   task automatic write_csr(input logic [1:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.order = e2q_pkg::order_type'(value[0]);
   endtask

   // drop valid and wait until every quaternion is back, plus pipeline slack
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_quats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // angle mix: full range, near zero, near the fold points and the extremes
   function automatic logic [AW-1:0] pick_angle();
      int k;
      k = $urandom_range(9);
      case (k)
         0, 1, 2, 3: return AW'($urandom);
         4, 5:       return AW'($signed($urandom_range(4000)) - 2000);
         6:          return AW'(($urandom_range(1) ? 102944 : -102944)
                                + $signed($urandom_range(64)) - 32);
         7:          return AW'(($urandom_range(1) ? 51472 : -51472)
                                + $signed($urandom_range(64)) - 32);
         8:          return $urandom_range(1) ? AW'(131071) : AW'(-131072);
         default:    return '0;
      endcase
   endfunction

   task automatic directed_set();
      logic [AW-1:0] vals[8];
      vals = '{AW'(0), AW'(131071), AW'(-131072), AW'(102944), AW'(-102944),
               AW'(51472), AW'(-51472), AW'(1)};
      // zero angles give exactly +1 for w, which must saturate
      send_angles('0, '0, '0);
      for (int i = 1; i < 8; i++) begin
         send_angles(vals[i], '0, '0);
         send_angles('0, vals[i], '0);
         send_angles('0, '0, vals[i]);
      end
      send_angles(AW'(131071), AW'(131071), AW'(131071));
      send_angles(AW'(-131072), AW'(-131072), AW'(-131072));
      send_angles(AW'(-1), AW'(-1), AW'(-1));
   endtask

   task automatic random_run(input int count, input bit with_hold);
      for (int i = 0; i < count; i++) begin
         // quiet stretch with no idling on either side
         idle_on = !(i >= count / 3 && i < count / 3 + 150);
         if (with_hold && i == count / 2) hold_req = 1;
         if (i == (2 * count) / 3) drain();
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      idle_on = 1;
   endtask

   initial begin
      sb = new();
      idle_on = 1;
      hold_req = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset order (1-2-3), then explicit 1-2-3 write
      directed_set();
      drain();
      write_csr(2'(e2q_pkg::ADDR_ROTATION_ORDER), {31'd0, e2q_pkg::ORDER_123});
      random_run(500, 1);
      drain();

      // 3-2-1 with junk in the upper register bits
      write_csr(2'(e2q_pkg::ADDR_ROTATION_ORDER), {31'($urandom), 1'b1});
      directed_set();
      random_run(500, 0);
      drain();

      // back to 1-2-3 with junk in the upper bits
      write_csr(2'(e2q_pkg::ADDR_ROTATION_ORDER), {31'($urandom), 1'b0});
      random_run(500, 0);
      drain();

      $display("covered %0d angle triples in both rotation orders, %0d results checked",
               sb.n_inputs, sb.n_results);
      $display("%0d saturated components, long receiver hold-off and drained pauses",
               sb.n_saturated);
      if (sb.errors == 0 && sb.pending_quats.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[euler_to_quaternion_top.f]
sv/e2q_pkg.sv
sv/e2q_cordic.sv
sv/e2q_combine.sv
sv/euler_to_quaternion_top.sv
verif/euler_to_quaternion_top_tb.sv
